// ===== rtl/itp_pkg.sv =====
// itp_pkg: shared types, constants and character helpers for the infix to prefix converter
// used by itp_ctrl, itp_datapath and the top level; depends on nothing else
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SYM_W = 8;

  localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;  // ^
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;  // *
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;  // /
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;  // +
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;  // -
  localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;  // (
  localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;  // )
  localparam logic [SYM_W-1:0] CH_D0    = 8'h30;
  localparam logic [SYM_W-1:0] CH_D9    = 8'h39;
  localparam logic [SYM_W-1:0] CH_UA    = 8'h41;
  localparam logic [SYM_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [SYM_W-1:0] CH_LA    = 8'h61;
  localparam logic [SYM_W-1:0] CH_LZ    = 8'h7A;

  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_ADD  = 2'd1;
  localparam logic [1:0] RANK_MUL  = 2'd2;
  localparam logic [1:0] RANK_POW  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PAREN,
    ST_OPER,
    ST_FLUSH,
    ST_FIN
  } itp_state_t;

  typedef struct packed {
    logic load;      // latch the input word
    logic emit_in;   // input symbol into the pending slot
    logic emit_top;  // top of stack into the pending slot
    logic pop;
    logic push;      // push the input symbol
    logic finish;    // close the item: pending slot or end marker to output
  } itp_cmd_t;

  typedef struct packed {
    logic       sym_alnum;
    logic       sym_open;
    logic       sym_close;
    logic [1:0] sym_rank;
    logic       last;
    logic       stack_empty;
    logic       top_close;
    logic       top_higher;
    logic       pend_valid;
    logic       out_free;
  } itp_status_t;

  function automatic logic [1:0] rank_of(input logic [SYM_W-1:0] ch);
    logic [1:0] r;
    r = RANK_NONE;
    if (ch == CH_CARET) r = RANK_POW;
    else if (ch == CH_STAR || ch == CH_SLASH) r = RANK_MUL;
    else if (ch == CH_PLUS || ch == CH_MINUS) r = RANK_ADD;
    return r;
  endfunction

  function automatic logic is_alnum(input logic [SYM_W-1:0] ch);
    return (ch >= CH_D0 && ch <= CH_D9) || (ch >= CH_UA && ch <= CH_UZ) ||
           (ch >= CH_LA && ch <= CH_LZ);
  endfunction

endpackage

// ===== rtl/itp_ctrl.sv =====
// itp_ctrl: sequencer for the infix to prefix converter, one stack step per cycle while the output is not stalled
// depends on itp_pkg; drives itp_datapath through itp_cmd_t
module itp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  itp_pkg::itp_status_t st,
  output itp_pkg::itp_cmd_t    cmd
);

  itp_pkg::itp_state_t state, state_next;
  logic emit_ok;

  // a new result may enter the pending slot if the old one can move out
  assign emit_ok = !st.pend_valid || st.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      itp_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = itp_pkg::ST_DISPATCH;
      end
      itp_pkg::ST_DISPATCH: begin
        if (st.sym_open) begin
          state_next = itp_pkg::ST_PAREN;
        end else if (st.sym_rank != itp_pkg::RANK_NONE) begin
          state_next = itp_pkg::ST_OPER;
        end else begin
          state_next = st.last ? itp_pkg::ST_FLUSH : itp_pkg::ST_FIN;
        end
      end
      itp_pkg::ST_PAREN: begin
        if (st.stack_empty || st.top_close) begin
          state_next = st.last ? itp_pkg::ST_FLUSH : itp_pkg::ST_FIN;
        end
      end
      itp_pkg::ST_OPER: begin
        if (st.stack_empty || !st.top_higher) begin
          state_next = st.last ? itp_pkg::ST_FLUSH : itp_pkg::ST_FIN;
        end
      end
      itp_pkg::ST_FLUSH: begin
        if (st.stack_empty) state_next = itp_pkg::ST_FIN;
      end
      itp_pkg::ST_FIN: begin
        if (!(st.pend_valid || st.last) || st.out_free) state_next = itp_pkg::ST_IDLE;
      end
      default: state_next = itp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      itp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      itp_pkg::ST_DISPATCH: begin
        // pending slot is always empty here
        if (st.sym_alnum) cmd.emit_in = 1'b1;
        if (st.sym_close) cmd.push = 1'b1;
      end
      itp_pkg::ST_PAREN: begin
        if (!st.stack_empty) begin
          if (st.top_close) begin
            cmd.pop = 1'b1;
          end else if (emit_ok) begin
            cmd.emit_top = 1'b1;
            cmd.pop      = 1'b1;
          end
        end
      end
      itp_pkg::ST_OPER: begin
        if (st.stack_empty || !st.top_higher) begin
          cmd.push = 1'b1;
        end else if (emit_ok) begin
          cmd.emit_top = 1'b1;
          cmd.pop      = 1'b1;
        end
      end
      itp_pkg::ST_FLUSH: begin
        if (!st.stack_empty && emit_ok) begin
          cmd.emit_top = 1'b1;
          cmd.pop      = 1'b1;
        end
      end
      itp_pkg::ST_FIN: begin
        cmd.finish = (st.pend_valid || st.last) && st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/itp_datapath.sv =====
// itp_datapath: operator stack memory, pending result slot and output register
// depends on itp_pkg; commanded by itp_ctrl
module itp_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  itp_pkg::itp_cmd_t            cmd,
  output itp_pkg::itp_status_t         st,
  input  logic [itp_pkg::SYM_W-1:0]    s_tdata,   // [7:0] symbol
  input  logic                        s_tlast,   // expr_last
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [itp_pkg::SYM_W-1:0]    m_tdata,   // [7:0] out_symbol
  output logic                        m_tlast,   // run_last
  output logic [2:0]                  m_tuser    // [0] has_symbol, [1] expr_end, [2] overflow
);

  logic [itp_pkg::SYM_W-1:0] stack_mem [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::CNT_W-1:0] count, count_next, count_m1;
  logic [itp_pkg::SYM_W-1:0] top, sym, pend_sym;
  logic                      last, overflow_seen, pend_valid, out_valid;
  logic [itp_pkg::SYM_W-1:0] out_symbol;
  logic                      has_symbol, run_last, expr_end, overflow;
  logic                      full, push_ok, emit, out_free;

  assign full     = count == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH);
  assign push_ok  = cmd.push && !full;
  assign emit     = cmd.emit_in || cmd.emit_top;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    count_next = count;
    if (push_ok) count_next = count + 1'b1;
    else if (cmd.pop) count_next = count - 1'b1;
  end
  assign count_m1 = count_next - 1'b1;

  // top always mirrors the entry below count, forwarded on a push
  always_ff @(posedge clk) begin
    if (push_ok) begin
      stack_mem[count[itp_pkg::PTR_W-1:0]] <= sym;
      top <= sym;
    end else if (count_next != '0) begin
      top <= stack_mem[count_m1[itp_pkg::PTR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.push && full) overflow_seen <= 1'b1;
      else if (cmd.finish && last) overflow_seen <= 1'b0;
      if (emit) pend_valid <= 1'b1;
      else if (cmd.finish) pend_valid <= 1'b0;
      if (cmd.finish || (emit && pend_valid)) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym  <= s_tdata;
      last <= s_tlast;
    end
    if (emit) pend_sym <= cmd.emit_top ? top : sym;
    if (cmd.finish) begin
      out_symbol <= pend_valid ? pend_sym : '0;
      has_symbol <= pend_valid;
      run_last   <= 1'b1;
      expr_end   <= last;
      overflow   <= last && overflow_seen;
    end else if (emit && pend_valid) begin
      // an earlier word of the same item: more results follow
      out_symbol <= pend_sym;
      has_symbol <= 1'b1;
      run_last   <= 1'b0;
      expr_end   <= 1'b0;
      overflow   <= 1'b0;
    end
  end

  always_comb begin
    st.sym_alnum   = itp_pkg::is_alnum(sym);
    st.sym_open    = sym == itp_pkg::CH_OPEN;
    st.sym_close   = sym == itp_pkg::CH_CLOSE;
    st.sym_rank    = itp_pkg::rank_of(sym);
    st.last        = last;
    st.stack_empty = count == '0;
    st.top_close   = top == itp_pkg::CH_CLOSE;
    st.top_higher  = itp_pkg::rank_of(top) > itp_pkg::rank_of(sym);
    st.pend_valid  = pend_valid;
    st.out_free    = out_free;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_symbol;
  assign m_tlast  = run_last;
  assign m_tuser  = {overflow, expr_end, has_symbol};

endmodule

// ===== rtl/infix_to_prefix_converter.sv =====
// infix_to_prefix_converter: top level, operator stack converter from infix to prefix order
// depends on itp_pkg, itp_ctrl and itp_datapath
//
//   port group | dir | tdata            | tlast     | tuser
//   s_*        | in  | [7:0] symbol     | expr_last | -
//   m_*        | out | [7:0] out_symbol | run_last  | [0] has_symbol [1] expr_end [2] overflow
//
// a letter, digit, ')' or ignored character goes from accept through decode and close
// to the next accept; an operator or '(' also pops stack entries one at a time before
// close, and a last character also flushes the stack entry by entry. the single-port stack
// memory allows one pop per cycle.
// reset empties the stack and clears the overflow flag; stack contents need no clear.
// a stalled output holds one word plus one pending word, then the pop sequence waits.
module infix_to_prefix_converter (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [itp_pkg::SYM_W-1:0] s_tdata,   // [7:0] symbol
  input  logic                     s_tlast,   // expr_last
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [itp_pkg::SYM_W-1:0] m_tdata,   // [7:0] out_symbol
  output logic                     m_tlast,   // run_last
  output logic [2:0]               m_tuser    // [0] has_symbol, [1] expr_end, [2] overflow
);

  itp_pkg::itp_cmd_t    cmd;
  itp_pkg::itp_status_t st;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  itp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/itp_checker.sv =====
// itp_checker: port-level assertions for the infix to prefix converter
// depends on itp_pkg; bound to infix_to_prefix_converter
module itp_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [itp_pkg::SYM_W-1:0] m_tdata,
  input logic                     m_tlast,
  input logic [2:0]               m_tuser
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output word changed while stalled");

  // one word at a time on the input side
  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on back to back cycles");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("expression end without run end");

  a_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tuser[1] && m_tdata == '0)
    else $error("bare marker not at expression end or nonzero");

  a_ovf_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1])
    else $error("overflow reported outside expression end");

endmodule

bind infix_to_prefix_converter itp_checker u_itp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ===== tb/tb.sv =====
// tb: self-checking bench for infix_to_prefix_converter, expressions fed right to left
// depends on itp_pkg and the converter rtl; a scoreboard class predicts the prefix stream
module tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS = 75;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] sym;
    logic       has_sym;
    logic       run_end;
    logic       expr_end;
    logic       ovf;
  } prefix_word_t;

  class prefix_scoreboard;
    logic [7:0]   op_stack[itp_pkg::STACK_DEPTH];
    int           depth_used;
    bit           dropped_push;
    prefix_word_t expected_q[$];
    int           mismatches;
    int           items_seen;
    int           words_checked;
    int           exprs_done;
    int           overflow_exprs;

    function new();
      depth_used = 0;
      dropped_push = 0;
      mismatches = 0;
      items_seen = 0;
      words_checked = 0;
      exprs_done = 0;
      overflow_exprs = 0;
    endfunction

    function logic [1:0] op_rank(logic [7:0] ch);
      case (ch)
        itp_pkg::CH_CARET: return itp_pkg::RANK_POW;
        itp_pkg::CH_STAR, itp_pkg::CH_SLASH: return itp_pkg::RANK_MUL;
        itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: return itp_pkg::RANK_ADD;
        default: return itp_pkg::RANK_NONE;
      endcase
    endfunction

    function bit is_operand(logic [7:0] ch);
      return (ch >= itp_pkg::CH_D0 && ch <= itp_pkg::CH_D9) ||
             (ch >= itp_pkg::CH_UA && ch <= itp_pkg::CH_UZ) ||
             (ch >= itp_pkg::CH_LA && ch <= itp_pkg::CH_LZ);
    endfunction

    function bit is_active(logic [7:0] ch);
      return is_operand(ch) || ch == itp_pkg::CH_OPEN || ch == itp_pkg::CH_CLOSE ||
             op_rank(ch) != itp_pkg::RANK_NONE;
    endfunction

    function void push_sym(logic [7:0] ch);
      if (depth_used >= itp_pkg::STACK_DEPTH) dropped_push = 1;
      else begin
        op_stack[depth_used] = ch;
        depth_used++;
      end
    endfunction

    function void note_symbol(logic [7:0] ch, logic last);
      prefix_word_t produced[$];
      prefix_word_t w;
      logic [1:0]   r;
      items_seen++;
      r = op_rank(ch);
      if (is_operand(ch)) begin
        produced.push_back('{ch, 1'b1, 1'b0, 1'b0, 1'b0});
      end else if (ch == itp_pkg::CH_CLOSE) begin
        push_sym(ch);
      end else if (ch == itp_pkg::CH_OPEN) begin
        while (depth_used > 0 && op_stack[depth_used-1] != itp_pkg::CH_CLOSE) begin
          depth_used--;
          produced.push_back('{op_stack[depth_used], 1'b1, 1'b0, 1'b0, 1'b0});
        end
        // the matching close paren is dropped silently
        if (depth_used > 0) depth_used--;
      end else if (r != itp_pkg::RANK_NONE) begin
        while (depth_used > 0 && op_rank(op_stack[depth_used-1]) > r) begin
          depth_used--;
          produced.push_back('{op_stack[depth_used], 1'b1, 1'b0, 1'b0, 1'b0});
        end
        push_sym(ch);
      end
      if (last) begin
        while (depth_used > 0) begin
          depth_used--;
          produced.push_back('{op_stack[depth_used], 1'b1, 1'b0, 1'b0, 1'b0});
        end
        if (produced.size() == 0) produced.push_back('{8'h00, 1'b0, 1'b0, 1'b0, 1'b0});
      end
      if (produced.size() > 0) begin
        w = produced.pop_back();
        w.run_end = 1'b1;
        if (last) begin
          w.expr_end = 1'b1;
          w.ovf = dropped_push;
          exprs_done++;
          if (dropped_push) overflow_exprs++;
        end
        produced.push_back(w);
      end
      if (last) dropped_push = 0;
      foreach (produced[i]) expected_q.push_back(produced[i]);
    endfunction

    function void check_word(logic [7:0] data, logic tl, logic [2:0] user);
      prefix_word_t got;
      prefix_word_t want;
      got = '{data, user[0], tl, user[1], user[2]};
      words_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected word: sym=%h has=%b run_end=%b expr_end=%b ovf=%b",
                   got.sym, got.has_sym, got.run_end, got.expr_end, got.ovf);
        return;
      end
      want = expected_q.pop_front();
      if (got.sym !== want.sym || got.has_sym !== want.has_sym ||
          got.run_end !== want.run_end || got.expr_end !== want.expr_end ||
          got.ovf !== want.ovf) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: want sym=%h has=%b run_end=%b expr_end=%b ovf=%b, got sym=%h has=%b run_end=%b expr_end=%b ovf=%b",
                   want.sym, want.has_sym, want.run_end, want.expr_end, want.ovf,
                   got.sym, got.has_sym, got.run_end, got.expr_end, got.ovf);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] symbol
  logic       s_tlast = 1'b0;    // expr_last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_symbol
  logic       m_tlast;           // run_last
  logic [2:0] m_tuser;           // [0] has_symbol, [1] expr_end, [2] overflow

  prefix_scoreboard sb;
  int               send_idle_pct = 13;
  int               recv_idle_pct = 84;
  int               quiet_cycles = 0;
  int               phase_items;
  logic [7:0]       expr_buf[$];
  logic [7:0]       op_chars[5];

  infix_to_prefix_converter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast, m_tuser);
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [7:0] ch, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_symbol(ch, last);
    if (sb.is_active(ch) || last) phase_items++;
  endtask

  // buffer holds the expression left to right; it goes out from the right end
  task automatic feed_buffer();
    for (int i = expr_buf.size() - 1; i >= 0; i--) send_word(expr_buf[i], i == 0);
  endtask

  task automatic feed_text(input string s);
    expr_buf.delete();
    for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
    feed_buffer();
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 2))
      0: return itp_pkg::CH_D0 + 8'($urandom_range(0, 9));
      1: return itp_pkg::CH_UA + 8'($urandom_range(0, 25));
      default: return itp_pkg::CH_LA + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic void build_expr(input int lvl);
    int terms;
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) expr_buf.push_back(op_chars[$urandom_range(0, 4)]);
      if (lvl < 3 && $urandom_range(0, 3) == 0) begin
        expr_buf.push_back(itp_pkg::CH_OPEN);
        build_expr(lvl + 1);
        expr_buf.push_back(itp_pkg::CH_CLOSE);
      end else begin
        expr_buf.push_back(pick_operand());
      end
    end
  endfunction

  // long runs of one pushed symbol, around the stack depth
  task automatic feed_deep_run(input int n);
    logic [7:0] ch;
    ch = ($urandom_range(0, 1) == 0) ? itp_pkg::CH_CLOSE : op_chars[$urandom_range(0, 4)];
    expr_buf.delete();
    expr_buf.push_back(pick_operand());
    repeat (n) expr_buf.push_back(ch);
    feed_buffer();
  endtask

  task automatic run_phase();
    int   kind;
    int   idx;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) begin
      kind = $urandom_range(0, 99);
      expr_buf.delete();
      if (kind < 65) begin
        build_expr(0);
        feed_buffer();
      end else if (kind < 82) begin
        build_expr(0);
        idx = $urandom_range(0, expr_buf.size() - 1);
        if ($urandom_range(0, 1) == 0 && expr_buf.size() > 1) expr_buf.delete(idx);
        else if ($urandom_range(0, 1) == 0) expr_buf[idx] = itp_pkg::CH_OPEN;
        else expr_buf[idx] = itp_pkg::CH_CLOSE;
        feed_buffer();
      end else if (kind < 96) begin
        repeat ($urandom_range(1, 6))
          send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        feed_deep_run($urandom_range(30, 40));
      end
    end
  endtask

  initial begin
    op_chars = '{itp_pkg::CH_CARET, itp_pkg::CH_STAR, itp_pkg::CH_SLASH,
                 itp_pkg::CH_PLUS, itp_pkg::CH_MINUS};
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    phase_items = 0;
    feed_text("z");
    feed_text("9^A*a-Z/0");
    feed_text("(");
    feed_text("a)");
    feed_text("(a+b");
    feed_text("((a))");
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
    // hold the input off until the output side has caught up
    wait_drained();

    feed_deep_run(34);
    for (int p = 0; p < 3; p++) begin
      if (p == 0) begin
        send_idle_pct = 13;
        recv_idle_pct = 84;
      end else if (p == 1) begin
        send_idle_pct = 84;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_phase();
      send_word(pick_operand(), 1'b1);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("run covered %0d input words and %0d result words over %0d expressions",
             sb.items_seen, sb.words_checked, sb.exprs_done);
    $display("%0d expressions hit a full stack, %0d mismatches", sb.overflow_exprs,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
